/* hw/rtl/slpu_pkg.sv */
// slpu_pkg: shared types, constants and arithmetic helpers for the
// subtractive lagged random generator. No dependencies.
package slpu_pkg;

	localparam int WORD_W          = 30;
	localparam int SEED_W          = 31;
	localparam int TABLE_DEPTH_DEF = 55;
	localparam int LAG_GAP         = 31;
	localparam int FILL_STEP       = 21;
	localparam int MIX_PASSES      = 4;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [SEED_W-1:0] seed_t;

	localparam word_t MOD_BIG      = 30'd1000000000;
	localparam seed_t MOD_BIG_SEED = 31'd1000000000;
	localparam seed_t SEED_BASE    = 31'd161803398;
	localparam seed_t DEFAULT_SEED = 31'd23410981;
	localparam word_t WORD_ONE     = 30'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_FILL,
		ST_PERM,
		ST_MIX,
		ST_DRAW
	} state_t;

	// source of the word entering the tail of the chain
	typedef enum logic [1:0] {
		SRC_LAG,
		SRC_FILL,
		SRC_SEED,
		SRC_ONE
	} src_t;

	typedef struct packed {
		logic shift_en;
		logic perm_en;
		src_t src;
		logic draw;
	} chain_ctrl_t;

	// (a - b) mod 10^9 for a, b below 10^9
	function automatic word_t mod_sub(input word_t a, input word_t b);
		logic [WORD_W:0] d;
		d = {1'b0, a} - {1'b0, b};
		if (d[WORD_W]) begin
			return d[WORD_W-1:0] + MOD_BIG;
		end
		return d[WORD_W-1:0];
	endfunction

endpackage

/* hw/rtl/slpu_cell.sv */
// slpu_cell: one table word of the lag chain. Shifts toward the head or
// takes a permuted load. Depends on slpu_pkg.
module slpu_cell
	import slpu_pkg::*;
(
	input  logic        clk,
	input  chain_ctrl_t ctl,
	input  word_t       shift_in,
	input  word_t       perm_in,
	output word_t       word
);

	word_t word_q;

	always_ff @(posedge clk) begin
		if (ctl.perm_en) begin
			word_q <= perm_in;
		end else if (ctl.shift_en) begin
			word_q <= shift_in;
		end
	end

	assign word = word_q;

endmodule

/* hw/rtl/slpu_ctrl.sv */
// slpu_ctrl: request handshake, seed register and the seeding sequencer
// (prep, fill, permute, mix). Depends on slpu_pkg.
module slpu_ctrl
	import slpu_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        restart,
	input  logic        out_free,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  seed_t       seed_value,
	output chain_ctrl_t ctl,
	output word_t       seed_word
);

	localparam int MIX_STEPS = MIX_PASSES * TABLE_DEPTH;
	localparam int CNT_W     = $clog2(MIX_STEPS);
	localparam logic [CNT_W-1:0] FILL_LAST = CNT_W'(TABLE_DEPTH - 1);
	localparam logic [CNT_W-1:0] MIX_LAST  = CNT_W'(MIX_STEPS - 1);
	localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	seed_t            seed_q;
	seed_t            abs_q;
	seed_t            seed_eff;
	logic             seeded_q;
	logic             mix_done;

	assign seed_eff  = (seed_q == '0) ? DEFAULT_SEED : seed_q;
	assign seed_word = (abs_q >= MOD_BIG_SEED) ? WORD_W'(abs_q - MOD_BIG_SEED)
	                                           : abs_q[WORD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			seed_q   <= '0;
			seeded_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cfg_valid && cfg_ready) begin
				seed_q   <= seed_value;
				seeded_q <= 1'b0;
			end else if (mix_done) begin
				seeded_q <= 1'b1;
			end
		end
	end

	// |161803398 - s|, reduced mod 10^9 on the first fill step
	always_ff @(posedge clk) begin
		if (state_q == ST_PREP) begin
			abs_q <= (seed_eff >= SEED_BASE) ? seed_eff - SEED_BASE : SEED_BASE - seed_eff;
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		in_ready     = 1'b0;
		cfg_ready    = 1'b0;
		mix_done     = 1'b0;
		ctl.shift_en = 1'b0;
		ctl.perm_en  = 1'b0;
		ctl.src      = SRC_LAG;
		ctl.draw     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = out_free;
				cfg_ready = 1'b1;
				if (in_valid && out_free) begin
					if (seeded_q && !restart) begin
						ctl.shift_en = 1'b1;
						ctl.draw     = 1'b1;
					end else begin
						state_d = ST_PREP;
					end
				end
			end
			ST_PREP: begin
				cnt_d   = '0;
				state_d = ST_FILL;
			end
			ST_FILL: begin
				ctl.shift_en = 1'b1;
				if (cnt_q == '0) begin
					ctl.src = SRC_SEED;
				end else if (cnt_q == CNT_ONE) begin
					ctl.src = SRC_ONE;
				end else begin
					ctl.src = SRC_FILL;
				end
				if (cnt_q == FILL_LAST) begin
					cnt_d   = '0;
					state_d = ST_PERM;
				end else begin
					cnt_d = cnt_q + CNT_ONE;
				end
			end
			ST_PERM: begin
				ctl.perm_en = 1'b1;
				cnt_d       = '0;
				state_d     = ST_MIX;
			end
			ST_MIX: begin
				ctl.shift_en = 1'b1;
				if (cnt_q == MIX_LAST) begin
					cnt_d    = '0;
					mix_done = 1'b1;
					state_d  = ST_DRAW;
				end else begin
					cnt_d = cnt_q + CNT_ONE;
				end
			end
			ST_DRAW: begin
				if (out_free) begin
					ctl.shift_en = 1'b1;
					ctl.draw     = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/subtractive_lagged_prng_unit.sv */
// Timing: a seeded request is drawn into the output register as it is taken; a request that seeds
// first (after reset, after a seed write, or with restart) runs prep, fill,
// permute, mix and draw in the cell chain; the draw waits for a free output.
// Throughput: one request and chain shift per cycle once seeded, if not stalled.
// Reset (arst_n, async low) clears control and seed; table is unseeded.
// Depends on slpu_pkg, slpu_cell, slpu_ctrl.
module subtractive_lagged_prng_unit
	import slpu_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  logic  restart,
	output logic  out_valid,
	input  logic  out_ready,
	output word_t random_value,
	input  logic  cfg_valid,
	output logic  cfg_ready,
	input  seed_t seed_value
);

	// Chain layout: cell j holds the table word at position lead+1+j (wrapping),
	// so cell 0 is the next leading word and cell LAG_GAP its trailing partner.
	// A draw shifts every cell toward the head and drops the difference into
	// the tail, which is the same position the head word came from. A mixing
	// pass over positions 1..55 is exactly 55 such steps, so mixing reuses it.

	chain_ctrl_t ctl;
	word_t       seed_word;
	word_t       cells [TABLE_DEPTH];
	word_t       op_a, op_b, diff, new_word;
	logic        out_valid_q;
	word_t       random_value_q;
	logic        out_free;

	assign out_free = !out_valid_q || out_ready;

	slpu_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.restart    (restart),
		.out_free   (out_free),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.seed_value (seed_value),
		.ctl        (ctl),
		.seed_word  (seed_word)
	);

	// Fill: words enter in draw order x0, x1, ... with x(k+1) = x(k-1) - x(k),
	// taken from the last two cells. Draw and mix: head minus lag tap.
	always_comb begin
		if (ctl.src == SRC_FILL) begin
			op_a = cells[TABLE_DEPTH-2];
			op_b = cells[TABLE_DEPTH-1];
		end else begin
			op_a = cells[0];
			op_b = cells[LAG_GAP];
		end
	end

	assign diff = mod_sub(op_a, op_b);

	always_comb begin
		case (ctl.src)
			SRC_SEED: new_word = seed_word;
			SRC_ONE:  new_word = WORD_ONE;
			default:  new_word = diff;
		endcase
	end

	// After the fill cell k holds x(k). Position p takes x(21*p mod 55), so
	// the permute load puts x(21*(j+1) mod 55) into cell j in one step.
	for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
		localparam int PERM_SRC = (FILL_STEP * (j + 1)) % TABLE_DEPTH;
		word_t shift_in;

		if (j == TABLE_DEPTH - 1) begin : g_tail
			assign shift_in = new_word;
		end else begin : g_body
			assign shift_in = cells[j+1];
		end

		slpu_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.shift_in (shift_in),
			.perm_in  (cells[PERM_SRC]),
			.word     (cells[j])
		);
	end

	// Output register: holds the result while it waits; a new request enters only once it is free or being taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.draw) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.draw) begin
			random_value_q <= diff;
		end
	end

	assign out_valid    = out_valid_q;
	assign random_value = random_value_q;

endmodule

/* hw/rtl/slpu_checker.sv */
// slpu_checker: port-level assertions for subtractive_lagged_prng_unit,
// attached by bind. Depends on slpu_pkg.
module slpu_checker
	import slpu_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input logic  out_valid,
	input logic  out_ready,
	input word_t random_value,
	input logic  cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(random_value))
		else $error("result changed while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> random_value < MOD_BIG)
		else $error("result not below 10^9");

	a_draw_or_seed: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid || !in_ready)
		else $error("request neither drawn nor seeding");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> cfg_ready)
		else $error("config port closed while idle");

endmodule

bind subtractive_lagged_prng_unit slpu_checker u_slpu_checker (.*);
